@@ hw/rtl/ctt_pkg.sv @@
package ctt_pkg;
	localparam int MAX_ROWS     = 64;
	localparam int MAX_SIDES    = 256;
	localparam int FRAC_BITS    = 14;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [1:0] {
		FUNC_SIDE   = 2'd0,
		FUNC_TOP    = 2'd1,
		FUNC_BOTTOM = 2'd2,
		FUNC_BAD    = 2'd3
	} func_t;

	localparam logic [1:0] CFG_ROWS   = 2'd0;
	localparam logic [1:0] CFG_SIDES  = 2'd1;
	localparam logic [1:0] CFG_RADIUS = 2'd2;

	// Rotation state handed from one CORDIC cell to the next.
	typedef struct packed {
		logic               vld;
		logic signed [33:0] x0;
		logic signed [33:0] y0;
		logic signed [33:0] z0;
		logic signed [33:0] x1;
		logic signed [33:0] y1;
		logic signed [33:0] z1;
	} rot_t;

	// Tile description carried alongside the rotations.
	typedef struct packed {
		logic               bad;
		logic [1:0]         func;
		logic [1:0]         quad0;
		logic [1:0]         quad1;
		logic signed [16:0] rad_in;
		logic signed [16:0] rad_out;
		logic signed [16:0] hgt_top;
		logic signed [16:0] hgt_bot;
	} tile_t;

	function automatic logic signed [33:0] atan_turn(input int i);
		logic signed [33:0] t [CORDIC_STEPS];
		t = '{34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
			34'sd42667331, 34'sd21354465, 34'sd10679838, 34'sd5340245,
			34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772, 34'sd166886,
			34'sd83443, 34'sd41722, 34'sd20861, 34'sd10430, 34'sd5215, 34'sd2608,
			34'sd1304, 34'sd652, 34'sd326, 34'sd163, 34'sd81, 34'sd41, 34'sd20,
			34'sd10, 34'sd5, 34'sd3, 34'sd1};
		return t[i];
	endfunction

	function automatic logic [15:0] sat16(input logic signed [47:0] v);
		if (v > 48'sd32767) return 16'h7fff;
		if (v < -48'sd32768) return 16'h8000;
		return v[15:0];
	endfunction
endpackage

@@ hw/rtl/ctt_div.sv @@
// Restoring divider, one quotient bit per cell, fully pipelined.
module ctt_div import ctt_pkg::*; #(
	parameter int NW = 40,
	parameter int DW = 12,
	parameter int TW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	logic [NW-1:0] q_q [NW+1];
	logic [DW-1:0] r_q [NW+1];
	logic [NW-1:0] n_q [NW+1];
	logic [DW-1:0] d_q [NW+1];
	logic [TW-1:0] t_q [NW+1];

	always_comb begin
		q_q[0] = '0;
		r_q[0] = '0;
		n_q[0] = num;
		d_q[0] = den;
		t_q[0] = tag_in;
	end

	for (genvar i = 0; i < NW; i++) begin : g_cell
		logic [DW:0] trial;
		assign trial = {r_q[i], n_q[i][NW-1-i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				t_q[i+1] <= '0;
			end else begin
				t_q[i+1] <= t_q[i];
			end
		end
		always_ff @(posedge clk) begin
			n_q[i+1] <= n_q[i];
			d_q[i+1] <= d_q[i];
			if (trial >= {1'b0, d_q[i]}) begin
				r_q[i+1] <= DW'(trial - {1'b0, d_q[i]});
				q_q[i+1] <= q_q[i] | (NW'(1) << (NW-1-i));
			end else begin
				r_q[i+1] <= trial[DW-1:0];
				q_q[i+1] <= q_q[i];
			end
		end
	end

	assign quo     = q_q[NW];
	assign tag_out = t_q[NW];
endmodule

@@ hw/rtl/ctt_cordic_cell.sv @@
// One rotation step for both wedge edges.
module ctt_cordic_cell import ctt_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  rot_t rot_in,
	output rot_t rot_out
);
	function automatic logic signed [33:0] fsh(input logic signed [33:0] v);
		return v >>> STEP;
	endfunction

	rot_t nxt;
	always_comb begin
		nxt = rot_in;
		if (rot_in.z0 >= 0) begin
			nxt.x0 = rot_in.x0 - fsh(rot_in.y0);
			nxt.y0 = rot_in.y0 + fsh(rot_in.x0);
			nxt.z0 = rot_in.z0 - atan_turn(STEP);
		end else begin
			nxt.x0 = rot_in.x0 + fsh(rot_in.y0);
			nxt.y0 = rot_in.y0 - fsh(rot_in.x0);
			nxt.z0 = rot_in.z0 + atan_turn(STEP);
		end
		if (rot_in.z1 >= 0) begin
			nxt.x1 = rot_in.x1 - fsh(rot_in.y1);
			nxt.y1 = rot_in.y1 + fsh(rot_in.x1);
			nxt.z1 = rot_in.z1 - atan_turn(STEP);
		end else begin
			nxt.x1 = rot_in.x1 + fsh(rot_in.y1);
			nxt.y1 = rot_in.y1 - fsh(rot_in.x1);
			nxt.z1 = rot_in.z1 + atan_turn(STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_out <= '0;
		end else begin
			rot_out <= nxt;
		end
	end
endmodule

@@ hw/rtl/cylinder_tile_tessellator_unit.sv @@
// Path from the accepting edge to the first vertex: 40 divider cells for the
// wedge phase, 30 CORDIC cells, then the quadrant, product and queue stages.
// The vertex emitter sends one vertex per cycle while out_stall is low; a good
// request yields six vertices and a rejected one a single vertex. The pipeline
// absorbs requests back to back while credit remains, up to 128 not yet emitted.
// Reset: arst_n asynchronous active low clears valids and restores registers.
module cylinder_tile_tessellator_unit import ctt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [7:0]         wedge_index,
	input  logic [5:0]         row_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [15:0] pos_z,
	output logic signed [15:0] norm_x,
	output logic signed [15:0] norm_y,
	output logic signed [15:0] norm_z,
	output logic [2:0]         vertex_slot,
	output logic               bad_request,
	output logic               last_vertex,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data
);
	localparam int ONE = 1 << FRAC_BITS;
	localparam int HALF = ONE / 2;
	// Pipeline depth from request to the first vertex.
	localparam int LAT = 40 + CORDIC_STEPS + 3;
	// Queue must hold every request in flight while the emitter drains their vertices.
	localparam int QD = 128;
	localparam int QA = $clog2(QD);

	logic [6:0]  rows_cfg_q;
	logic [8:0]  sides_cfg_q;
	logic [14:0] radius_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= 7'd1;
			sides_cfg_q <= 9'd3;
			radius_q    <= 15'd8192;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_ROWS:   rows_cfg_q  <= cfg_data[6:0];
				CFG_SIDES:  sides_cfg_q <= cfg_data[8:0];
				CFG_RADIUS: radius_q    <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Effective counts.
	logic [8:0] rows_eff, sides_eff;
	always_comb begin
		rows_eff  = (32'(rows_cfg_q) > MAX_ROWS) ? 9'(MAX_ROWS) : 9'(rows_cfg_q);
		sides_eff = (sides_cfg_q < 9'd3) ? 9'd3 : sides_cfg_q;
		if (32'(sides_eff) > MAX_SIDES) sides_eff = 9'(MAX_SIDES);
	end

	// Credit count of requests admitted but not yet emitted.
	logic [QA:0] credit_q;
	logic        acc_in, pop;
	assign in_stall = (credit_q == (QA+1)'(QD));
	assign acc_in   = in_valid && !in_stall;

	// Stage 1: validate and set up four dividers per request (two phases, two
	// row fractions). Row fraction divisor 2R for caps, R for the side.
	logic        bad_s1;
	logic [39:0] n0, n1, nr0, nr1;
	logic [11:0] dph, drow;
	always_comb begin
		bad_s1 = (func == FUNC_BAD) || ({1'b0, wedge_index} >= sides_eff)
			|| ({3'b0, row_index} >= rows_eff);
		n0  = ({8'(wedge_index), 32'd0}) + 40'(sides_eff >> 1);
		n1  = (40'(9'(wedge_index) + 9'd1) << 32) + 40'(sides_eff >> 1);
		drow = (func == FUNC_SIDE) ? 12'(rows_eff) : 12'(rows_eff) << 1;
		nr0 = 40'(row_index) * 40'(ONE) + 40'(drow >> 1);
		nr1 = (40'(row_index) + 40'd1) * 40'(ONE) + 40'(drow >> 1);
		dph = 12'(sides_eff);
	end

	typedef struct packed {
		logic       vld;
		logic       bad;
		logic [1:0] func;
	} tag_t;
	tag_t tag_in, tag_a, tag_b, tag_c, tag_d;
	assign tag_in = '{vld: acc_in, bad: bad_s1, func: func};

	logic [39:0] q0, q1, qr0, qr1;
	ctt_div #(.NW(40), .DW(12), .TW(4)) u_div0 (.clk, .arst_n, .num(n0), .den(dph),
		.tag_in(tag_in), .quo(q0), .tag_out(tag_a));
	ctt_div #(.NW(40), .DW(12), .TW(4)) u_div1 (.clk, .arst_n, .num(n1), .den(dph),
		.tag_in(tag_in), .quo(q1), .tag_out(tag_b));
	ctt_div #(.NW(40), .DW(12), .TW(4)) u_div2 (.clk, .arst_n, .num(nr0), .den(drow),
		.tag_in(tag_in), .quo(qr0), .tag_out(tag_c));
	ctt_div #(.NW(40), .DW(12), .TW(4)) u_div3 (.clk, .arst_n, .num(nr1), .den(drow),
		.tag_in(tag_in), .quo(qr1), .tag_out(tag_d));

	// Build tile and enter CORDIC chain.
	logic [31:0] ph0, ph1;
	assign ph0 = q0[31:0];
	assign ph1 = q1[31:0];

	rot_t  rot [CORDIC_STEPS+1];
	tile_t tile [CORDIC_STEPS+1];
	tile_t tile0;
	always_comb begin
		rot[0].vld = tag_a.vld;
		rot[0].x0  = CORDIC_GAIN;
		rot[0].y0  = '0;
		rot[0].z0  = {4'd0, ph0[29:0]};
		rot[0].x1  = CORDIC_GAIN;
		rot[0].y1  = '0;
		rot[0].z1  = {4'd0, ph1[29:0]};
		tile0.bad   = tag_a.bad;
		tile0.func  = tag_a.func;
		tile0.quad0 = ph0[31:30];
		tile0.quad1 = ph1[31:30];
		if (tag_a.func == FUNC_SIDE) begin
			tile0.rad_in  = 17'(radius_q);
			tile0.rad_out = 17'(radius_q);
			tile0.hgt_top = 17'sd0 + 17'(HALF) - 17'(qr0);
			tile0.hgt_bot = 17'(HALF) - 17'(qr1);
		end else begin
			tile0.rad_in  = 17'(qr0);
			tile0.rad_out = 17'(qr1);
			tile0.hgt_top = (tag_a.func == FUNC_TOP) ? 17'(HALF) : -17'(HALF);
			tile0.hgt_bot = tile0.hgt_top;
		end
	end
	assign tile[0] = tile0;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		ctt_cordic_cell #(.STEP(i)) u_cell (.clk, .arst_n, .rot_in(rot[i]),
			.rot_out(rot[i+1]));
		always_ff @(posedge clk) tile[i+1] <= tile[i];
	end

	// Quadrant fix-up, registered.
	logic signed [33:0] c0_s1, s0_s1, c1_s1, s1_s1;
	logic               vld_p1;
	tile_t              tile_p1;
	function automatic logic signed [67:0] quad_fix(input logic [1:0] q,
		input logic signed [33:0] x, input logic signed [33:0] y);
		case (q)
			2'd1:    return {-y, x};
			2'd2:    return {-x, -y};
			2'd3:    return {y, -x};
			default: return {x, y};
		endcase
	endfunction
	logic signed [67:0] f0, f1;
	assign f0 = quad_fix(tile[CORDIC_STEPS].quad0, rot[CORDIC_STEPS].x0, rot[CORDIC_STEPS].y0);
	assign f1 = quad_fix(tile[CORDIC_STEPS].quad1, rot[CORDIC_STEPS].x1, rot[CORDIC_STEPS].y1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_p1 <= 1'b0;
		else vld_p1 <= rot[CORDIC_STEPS].vld;
	end
	always_ff @(posedge clk) begin
		c0_s1 <= f0[67:34]; s0_s1 <= f0[33:0];
		c1_s1 <= f1[67:34]; s1_s1 <= f1[33:0];
		tile_p1 <= tile[CORDIC_STEPS];
	end

	// Eight products radius*cos/sin, then round. Corners: TL,BL angle0; TR,BR angle1.
	logic signed [51:0] p_q [8];
	logic               vld_p2;
	tile_t              tile_p2;
	logic signed [33:0] c0_s2, s0_s2, c1_s2, s1_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_p2 <= 1'b0;
		else vld_p2 <= vld_p1;
	end
	always_ff @(posedge clk) begin
		p_q[0] <= tile_p1.rad_in  * c0_s1; // TL x
		p_q[1] <= tile_p1.rad_in  * s0_s1; // TL z
		p_q[2] <= tile_p1.rad_in  * c1_s1; // TR
		p_q[3] <= tile_p1.rad_in  * s1_s1;
		p_q[4] <= tile_p1.rad_out * c0_s1; // BL
		p_q[5] <= tile_p1.rad_out * s0_s1;
		p_q[6] <= tile_p1.rad_out * c1_s1; // BR
		p_q[7] <= tile_p1.rad_out * s1_s1;
		tile_p2 <= tile_p1;
		c0_s2 <= c0_s1; s0_s2 <= s0_s1; c1_s2 <= c1_s1; s1_s2 <= s1_s1;
	end

	function automatic logic [15:0] rnd(input logic signed [51:0] v, input int s);
		logic signed [51:0] t;
		t = (v + (52'sd1 <<< (s - 1))) >>> s;
		return sat16(t[47:0]);
	endfunction

	// Queue entry: four corners of positions and two normals.
	typedef struct packed {
		logic       bad;
		logic [1:0] func;
		logic [15:0] x_tl, z_tl, x_tr, z_tr, x_bl, z_bl, x_br, z_br;
		logic [15:0] y_top, y_bot;
		logic [15:0] nx0, nz0, nx1, nz1;
	} ent_t;
	ent_t ent_w;
	always_comb begin
		ent_w.bad  = tile_p2.bad;
		ent_w.func = tile_p2.func;
		ent_w.x_tl = rnd(p_q[0], 30); ent_w.z_tl = rnd(p_q[1], 30);
		ent_w.x_tr = rnd(p_q[2], 30); ent_w.z_tr = rnd(p_q[3], 30);
		ent_w.x_bl = rnd(p_q[4], 30); ent_w.z_bl = rnd(p_q[5], 30);
		ent_w.x_br = rnd(p_q[6], 30); ent_w.z_br = rnd(p_q[7], 30);
		ent_w.y_top = sat16(48'(tile_p2.hgt_top));
		ent_w.y_bot = sat16(48'(tile_p2.hgt_bot));
		ent_w.nx0 = rnd(52'(c0_s2), 30 - FRAC_BITS);
		ent_w.nz0 = rnd(52'(s0_s2), 30 - FRAC_BITS);
		ent_w.nx1 = rnd(52'(c1_s2), 30 - FRAC_BITS);
		ent_w.nz1 = rnd(52'(s1_s2), 30 - FRAC_BITS);
	end

	// Queue memory with registered read.
	ent_t        mem [QD];
	logic [QA:0] wp_q, rp_q;
	always_ff @(posedge clk) begin
		if (vld_p2) mem[wp_q[QA-1:0]] <= ent_w;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wp_q <= '0;
		else if (vld_p2) wp_q <= wp_q + (QA+1)'(1);
	end

	// Emitter: fetch entry into a hold register, then walk six slots (one if rejected).
	ent_t       cur_q;
	logic       cur_vld_q;
	logic [2:0] slot_q;
	logic       rd_pend_q;
	logic       fetch;
	logic       last_now;
	assign last_now = cur_q.bad || (slot_q == 3'd5);
	assign pop   = out_valid && !out_stall && last_now;
	assign fetch = (wp_q != rp_q) && !rd_pend_q && (!cur_vld_q || pop);

	always_ff @(posedge clk) begin
		if (fetch) cur_q <= mem[rp_q[QA-1:0]];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q      <= '0;
			cur_vld_q <= 1'b0;
			slot_q    <= '0;
			rd_pend_q <= 1'b0;
			credit_q  <= '0;
		end else begin
			rd_pend_q <= 1'b0;
			if (fetch) begin
				rp_q      <= rp_q + (QA+1)'(1);
				cur_vld_q <= 1'b1;
				slot_q    <= '0;
			end else if (pop) begin
				cur_vld_q <= 1'b0;
			end else if (out_valid && !out_stall) begin
				slot_q <= slot_q + 3'd1;
			end
			credit_q <= credit_q + (QA+1)'(acc_in) - (QA+1)'(pop);
		end
	end

	// Corner order: side/top TL,BR,BL,TL,TR,BR; bottom BR,TL,BL,BR,TR,TL.
	logic [1:0] corner;
	always_comb begin
		if (cur_q.func == FUNC_BOTTOM) begin
			case (slot_q)
				3'd0, 3'd3: corner = 2'd3;
				3'd1, 3'd5: corner = 2'd0;
				3'd2:       corner = 2'd2;
				default:    corner = 2'd1;
			endcase
		end else begin
			case (slot_q)
				3'd0, 3'd3: corner = 2'd0;
				3'd1, 3'd5: corner = 2'd3;
				3'd2:       corner = 2'd2;
				default:    corner = 2'd1;
			endcase
		end
	end

	assign out_valid = cur_vld_q;
	always_comb begin
		pos_x = '0; pos_y = '0; pos_z = '0;
		norm_x = '0; norm_y = '0; norm_z = '0;
		vertex_slot = slot_q;
		bad_request = cur_q.bad;
		last_vertex = last_now;
		if (cur_q.bad) begin
			vertex_slot = '0;
		end else begin
			case (corner)
				2'd0: begin pos_x = cur_q.x_tl; pos_z = cur_q.z_tl; end
				2'd1: begin pos_x = cur_q.x_tr; pos_z = cur_q.z_tr; end
				2'd2: begin pos_x = cur_q.x_bl; pos_z = cur_q.z_bl; end
				default: begin pos_x = cur_q.x_br; pos_z = cur_q.z_br; end
			endcase
			pos_y = corner[1] ? cur_q.y_bot : cur_q.y_top;
			if (cur_q.func == FUNC_SIDE) begin
				norm_x = corner[0] ? cur_q.nx1 : cur_q.nx0;
				norm_z = corner[0] ? cur_q.nz1 : cur_q.nz0;
			end else begin
				norm_y = (cur_q.func == FUNC_TOP) ? 16'(ONE) : -16'(ONE);
			end
		end
	end

	logic unused_tags;
	assign unused_tags = ^{tag_b, tag_c, tag_d, q0[39:32], q1[39:32], qr0[39:17],
		qr1[39:17], LAT[0]};
endmodule

@@ hw/rtl/ctt_checker.sv @@
module ctt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] vertex_slot,
	input logic       bad_request,
	input logic       last_vertex
);
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> vertex_slot <= 3'd5) else $error("slot out of range");
	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_request |-> last_vertex) else $error("bad without last");
	a_slot_adv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_vertex |=> out_valid
		&& vertex_slot == $past(vertex_slot) + 3'd1) else $error("slot skip");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vertex_slot))
		else $error("stalled transaction changed");
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid) else $error("stalled request dropped");
endmodule

bind cylinder_tile_tessellator_unit ctt_checker u_ctt_checker (.*);

@@ tb/sv/tb_cylinder_tile_tessellator_unit.sv @@
module tb_cylinder_tile_tessellator_unit;
	import ctt_pkg::*;

	localparam int ONE        = 1 << 14;
	localparam int DRAIN_WAIT = 100;   // a bit more than the pipeline depth
	localparam int STALL_MAX  = 4000;  // cycles with no transaction at all

	// One vertex as it leaves the block.
	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic [2:0]         slot;
		logic               bad;
		logic               last;
	} vertex_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic [7:0]         wedge_index;
	logic [5:0]         row_index;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z;
	logic [2:0]         vertex_slot;
	logic               bad_request;
	logic               last_vertex;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [14:0]        cfg_data;

	cylinder_tile_tessellator_unit dut (.*);

	// Shadow copy of the three registers.
	logic [6:0]  sh_rows;
	logic [8:0]  sh_sides;
	logic [14:0] sh_radius;

	vertex_t vertex_queue[$];
	int      mismatches;
	int      tiles_sent;
	int      vertices_seen;
	int      idle_cycles;
	bit      quiet;   // when set, neither side idles

	longint arctan_table [30] = '{536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
		41, 20, 10, 5, 3, 1};

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic logic [15:0] clip16(input longint v);
		if (v > 32767)
			return 16'h7fff;
		if (v < -32768)
			return 16'h8000;
		return v[15:0];
	endfunction

	function automatic longint round_q(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// Rotation CORDIC on the phase within its quadrant, quadrant applied after.
	function automatic void cos_sin(input logic [31:0] ph, output longint c, output longint s);
		longint x, y, z, dx, dy;
		x = 652032874;
		y = 0;
		z = longint'(ph[29:0]);
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arctan_table[i];
			end else begin
				x += dx; y -= dy; z += arctan_table[i];
			end
		end
		case (ph[31:30])
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			2'd3: begin c = y; s = -x; end
			default: begin c = x; s = y; end
		endcase
	endfunction

	function automatic logic [31:0] phase_of(input int w, input int n);
		longint unsigned num;
		num = (longint'(w) << 32) + n / 2;
		return 32'(num / n);
	endfunction

	function automatic int live_rows();
		return (sh_rows > 64) ? 64 : sh_rows;
	endfunction

	function automatic int live_sides();
		return (sh_sides < 3) ? 3 : ((sh_sides > 256) ? 256 : sh_sides);
	endfunction

	// Queue the vertices one tile request is expected to produce.
	function automatic void predict_tile(input logic [1:0] f, input int w, input int row);
		int      order_up [6] = '{0, 3, 2, 0, 1, 3};
		int      order_dn [6] = '{3, 0, 2, 3, 1, 0};
		int      rows, sides, cn, ang;
		longint  cs [2], sn [2], rad [4], hgt [4], top, bot, y;
		vertex_t v;
		rows  = live_rows();
		sides = live_sides();
		v = '0;
		if (f == FUNC_BAD || w >= sides || row >= rows) begin
			v.bad  = 1'b1;
			v.last = 1'b1;
			vertex_queue = {vertex_queue, v};
			return;
		end
		cos_sin(phase_of(w, sides), cs[0], sn[0]);
		cos_sin(phase_of(w + 1, sides), cs[1], sn[1]);
		if (f == FUNC_SIDE) begin
			top = ONE / 2 - (longint'(row) * ONE + rows / 2) / rows;
			bot = ONE / 2 - (longint'(row + 1) * ONE + rows / 2) / rows;
			for (int k = 0; k < 4; k++)
				rad[k] = sh_radius;
			hgt[0] = top; hgt[1] = top;
			hgt[2] = bot; hgt[3] = bot;
		end else begin
			y = (f == FUNC_TOP) ? ONE / 2 : -(ONE / 2);
			rad[0] = (longint'(row) * ONE + rows) / (2 * rows);
			rad[1] = rad[0];
			rad[2] = (longint'(row + 1) * ONE + rows) / (2 * rows);
			rad[3] = rad[2];
			for (int k = 0; k < 4; k++)
				hgt[k] = y;
		end
		for (int k = 0; k < 6; k++) begin
			cn  = (f == FUNC_BOTTOM) ? order_dn[k] : order_up[k];
			ang = cn & 1;
			v = '0;
			v.px = clip16(round_q(rad[cn] * cs[ang], 30));
			v.py = clip16(hgt[cn]);
			v.pz = clip16(round_q(rad[cn] * sn[ang], 30));
			if (f == FUNC_SIDE) begin
				v.nx = clip16(round_q(cs[ang], 16));
				v.nz = clip16(round_q(sn[ang], 16));
			end else begin
				v.ny = (f == FUNC_TOP) ? 16'sd16384 : -16'sd16384;
			end
			v.slot = 3'(k);
			v.last = (k == 5);
			vertex_queue = {vertex_queue, v};
		end
	endfunction

	// Output side: random back-pressure, result checking and the watchdog.
	always @(posedge clk) begin
		vertex_t exp_v;
		vertex_t got_v;
		out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 26);
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_MAX) begin
				$display("watchdog: no transaction for %0d cycles, %0d vertices pending",
					STALL_MAX, vertex_queue.size());
				$display("cylinder_tile_tessellator_unit test failed");
				$finish;
			end
			if (out_valid && !out_stall) begin
				got_v = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
					vertex_slot, bad_request, last_vertex};
				vertices_seen++;
				if (vertex_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected vertex %p", got_v);
				end else begin
					exp_v = vertex_queue.pop_front();
					if (got_v !== exp_v) begin
						mismatches++;
						if (mismatches <= 10)
							$display("vertex mismatch\n  expected %p\n  actual   %p", exp_v, got_v);
					end
				end
			end
		end
	end

	// Drive one tile request and hold it until the block takes the transaction.
	task automatic send_tile(input logic [1:0] f, input int w, input int row);
		while (!quiet && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		wedge_index <= 8'(w);
		row_index   <= 6'(row);
		do
			@(posedge clk);
		while (in_stall);
		predict_tile(f, w, row);
		tiles_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (vertex_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Registers change only with the pipeline empty.
	task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ROWS:   sh_rows   = data[6:0];
			CFG_SIDES:  sh_sides  = data[8:0];
			CFG_RADIUS: sh_radius = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_shape(input int rows, input int sides, input int radius);
		write_reg(CFG_ROWS, 15'(rows));
		write_reg(CFG_SIDES, 15'(sides));
		write_reg(CFG_RADIUS, 15'(radius));
	endtask

	task automatic test_reset_values();
		send_tile(FUNC_SIDE, 0, 0);
		send_tile(FUNC_TOP, 2, 0);
		send_tile(FUNC_BOTTOM, 1, 0);
		send_tile(FUNC_SIDE, 3, 0);   // wedge past the three default sides
	endtask

	// Extremes of every field and each special case.
	task automatic test_directed();
		set_shape(64, 256, 16384);
		send_tile(FUNC_SIDE, 0, 0);
		send_tile(FUNC_SIDE, 255, 63);
		send_tile(FUNC_TOP, 128, 31);
		send_tile(FUNC_BOTTOM, 255, 63);
		send_tile(FUNC_BAD, 0, 0);
		send_tile(FUNC_BAD, 255, 63);
		// Zero rows reject everything.
		set_shape(0, 5, 16384);
		send_tile(FUNC_SIDE, 0, 0);
		send_tile(FUNC_TOP, 4, 0);
		// Counts above the maximum clamp; sides below three act as three.
		set_shape(127, 0, 32767);
		send_tile(FUNC_SIDE, 2, 63);
		send_tile(FUNC_BOTTOM, 3, 10);
		set_shape(64, 511, 0);
		send_tile(FUNC_SIDE, 255, 0);   // zero radius collapses onto the axis
		send_tile(FUNC_TOP, 170, 42);
		set_shape(1, 2, 1);
		send_tile(FUNC_SIDE, 1, 0);
		send_tile(FUNC_BOTTOM, 2, 0);
		send_tile(FUNC_TOP, 0, 1);
	endtask

	// Hold the sender until every pending vertex has come back.
	task automatic test_pause();
		send_tile(FUNC_SIDE, 1, 0);
		send_tile(FUNC_TOP, 0, 0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (vertex_queue.size() != 0)
			@(posedge clk);
		send_tile(FUNC_BOTTOM, 2, 0);
	endtask

	task automatic test_random(input int count);
		int rows, sides, w, row;
		logic [1:0] f;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_shape(64, 256, 16384);
				1: set_shape(1, 3, 1);
				2: set_shape($urandom_range(0, 127), $urandom_range(0, 511), $urandom_range(0, 32767));
				default: set_shape($urandom_range(1, 64), $urandom_range(3, 256), $urandom_range(1, 16384));
			endcase
			quiet = (p == 3);   // one long stretch with no idling on either side
			rows  = live_rows();
			sides = live_sides();
			for (int n = 0; n < count / 8; n++) begin
				if ($urandom_range(99) < 85 && rows > 0) begin
					f   = 2'($urandom_range(0, 2));
					w   = $urandom_range(0, ((sides > 256) ? 256 : sides) - 1);
					row = $urandom_range(0, rows - 1);
				end else begin
					f   = 2'($urandom_range(0, 3));
					w   = $urandom_range(0, 255);
					row = $urandom_range(0, 63);
				end
				send_tile(f, w, row);
			end
			quiet = 1'b0;
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = FUNC_SIDE;
		wedge_index = '0;
		row_index   = '0;
		out_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_ROWS;
		cfg_data    = '0;
		sh_rows     = 7'd1;
		sh_sides    = 9'd3;
		sh_radius   = 15'd8192;
		mismatches  = 0;
		tiles_sent  = 0;
		vertices_seen = 0;
		idle_cycles = 0;
		quiet       = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed();
		test_pause();
		test_random(288);

		in_valid <= 1'b0;
		@(posedge clk);
		while (vertex_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d tile requests (side, caps, rejects) yielding %0d vertices",
			tiles_sent, vertices_seen);
		$display("register settings included zero, clamped and extreme counts and radii");
		if (mismatches == 0 && vertex_queue.size() == 0) begin
			$display("cylinder_tile_tessellator_unit test passed");
		end else begin
			$display("%0d mismatches, %0d vertices never came", mismatches, vertex_queue.size());
			$display("cylinder_tile_tessellator_unit test failed");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
hw/rtl/ctt_pkg.sv
hw/rtl/ctt_div.sv
hw/rtl/ctt_cordic_cell.sv
hw/rtl/cylinder_tile_tessellator_unit.sv
hw/rtl/ctt_checker.sv
tb/sv/tb_cylinder_tile_tessellator_unit.sv
